>>> hdl/gmc_pkg.sv
package gmc_pkg;

  // Largest graph the search handles; adjacency rows carry one bit per vertex.
  localparam int MAX_VERTICES = 16;
  localparam int VIDX_W       = $clog2(MAX_VERTICES);
  localparam int VPTR_W       = $clog2(MAX_VERTICES + 1);
  localparam int COLOR_W      = 5;
  localparam int ROW_W        = 16;
  localparam int CFG_W        = 5;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_SOLVE = 1'b1
  } op_t;

  typedef enum logic {
    REG_COLOR_LIMIT  = 1'b0,
    REG_VERTEX_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CLEAR,
    S_VISIT,
    S_TRY,
    S_FINISH
  } state_t;

  typedef struct packed {
    logic write_row;
    logic clear;
    logic visit;
    logic place;
    logic back;
    logic next_c;
    logic load_result;
    logic found;
  } cmd_t;

  typedef struct packed {
    logic v_done;
    logic v_zero;
    logic c_over;
    logic safe;
    logic out_busy;
  } status_t;

endpackage

>>> hdl/graph_m_coloring_backtrack.sv
// Graph colouring decider with a backtracking search.
//
// Input items arrive on the s_ stream. With s_tuser low an item loads one
// adjacency row: row_index in s_tdata[3:0], row_bits in s_tdata[19:4]. Such an
// item produces no result. With s_tuser high an item starts
// a search over the first vertex_count vertices using at most color_limit
// colours, and one result item comes out on the m_ stream with m_tdata[0] set
// when a valid colouring exists.
// A search item is followed by a step that clears the colour store, a visit of
// each vertex (the closing check that all are placed included), a trial of each
// colour tried and a step each time a vertex runs out of colours, then the
// loading of the output register. s_tready stays low meanwhile, so the next
// item goes in only once the answer has been loaded.
// The result sits in an output register. If the receiver stalls, new row loads
// and a new search are still taken; a finished search waits for the register to
// empty before handing over its answer.
// Reset (synchronous, active high) clears the controller, the colour store and
// the output valid, and sets color_limit to 3 and vertex_count to 4; adjacency
// rows hold no value until loaded. Registers sit on an APB port: color_limit at
// address 0, vertex_count at address 4.
module graph_m_coloring_backtrack (
  input  logic        clk,
  input  logic        rst,
  // APB configuration port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [23:0] s_tdata,   // row_index [3:0], row_bits [19:4], zero [23:20]
  input  logic [0:0]  s_tuser,   // operation [0]
  // Output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata    // colorable [0], zero [7:1]
);
  import gmc_pkg::*;

  logic [CFG_W-1:0] color_limit;
  logic [CFG_W-1:0] vertex_count;
  logic             cfg_write;
  reg_idx_t         cfg_sel;
  cmd_t             cmd;
  status_t          status;
  logic             colorable;

  assign pready    = 1'b1;
  assign cfg_sel   = reg_idx_t'(paddr[2]);
  assign cfg_write = psel && penable && pwrite && pready;

  // Configuration registers; the upper data bits are dropped on a write.
  always_ff @(posedge clk) begin
    if (rst) begin
      color_limit  <= CFG_W'(3);
      vertex_count <= CFG_W'(4);
    end else if (cfg_write) begin
      unique case (cfg_sel)
        REG_COLOR_LIMIT:  color_limit  <= pwdata[CFG_W-1:0];
        REG_VERTEX_COUNT: vertex_count <= pwdata[CFG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_COLOR_LIMIT:  prdata = {{(32-CFG_W){1'b0}}, color_limit};
      REG_VERTEX_COUNT: prdata = {{(32-CFG_W){1'b0}}, vertex_count};
      default:          prdata = '0;
    endcase
  end

  // The controller sequences the search; the datapath holds the graph,
  // the colour store and the vertex pointer.
  gmc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_op     (s_tuser[0]),
    .status   (status),
    .cmd      (cmd)
  );

  gmc_dpath u_dpath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .row_index    (s_tdata[VIDX_W-1:0]),
    .row_bits     (s_tdata[VIDX_W+ROW_W-1:VIDX_W]),
    .color_limit  (color_limit),
    .vertex_count (vertex_count),
    .m_tready     (m_tready),
    .m_tvalid     (m_tvalid),
    .colorable    (colorable)
  );

  assign m_tdata = {7'b0, colorable};

  // A search item closes the input until its answer is ready.
  a_solve_blocks: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && s_tuser[0] == OP_SOLVE |=> !s_tready)
    else $error("input stayed open after a search item");

  // The answer never overwrites an item still held by a stalled receiver.
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |-> !status.out_busy)
    else $error("result register overwritten while stalled");

  // The datapath is given at most one action per cycle.
  a_one_action: assert property (@(posedge clk) disable iff (rst)
    $onehot0({cmd.write_row, cmd.clear, cmd.visit, cmd.place, cmd.back,
              cmd.next_c, cmd.load_result}))
    else $error("conflicting datapath commands");

endmodule

>>> hdl/gmc_ctrl.sv
module gmc_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic             s_op,
  input  gmc_pkg::status_t status,
  output gmc_pkg::cmd_t    cmd
);
  import gmc_pkg::*;

  state_t state, state_next;
  logic   found, found_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      found <= 1'b0;
    end else begin
      state <= state_next;
      found <= found_next;
    end
  end

  // Next state and the answer to be delivered.
  always_comb begin
    state_next = state;
    found_next = found;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid && op_t'(s_op) == OP_SOLVE) state_next = S_CLEAR;
      end
      S_CLEAR: state_next = S_VISIT;
      S_VISIT: begin
        if (status.v_done) begin
          found_next = 1'b1;
          state_next = S_FINISH;
        end else begin
          state_next = S_TRY;
        end
      end
      S_TRY: begin
        priority if (status.c_over) begin
          if (status.v_zero) begin
            found_next = 1'b0;
            state_next = S_FINISH;
          end else begin
            state_next = S_VISIT;
          end
        end else if (status.safe) begin
          state_next = S_VISIT;
        end else begin
          state_next = S_TRY;
        end
      end
      S_FINISH: begin
        if (!status.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd      = '0;
    s_tready = 1'b0;
    cmd.found = found;
    unique case (state)
      S_IDLE: begin
        s_tready      = 1'b1;
        cmd.write_row = s_tvalid && op_t'(s_op) == OP_LOAD;
      end
      S_CLEAR: cmd.clear = 1'b1;
      S_VISIT: cmd.visit = !status.v_done;
      S_TRY: begin
        priority if (status.c_over) begin
          cmd.back = !status.v_zero;
        end else if (status.safe) begin
          cmd.place = 1'b1;
        end else begin
          cmd.next_c = 1'b1;
        end
      end
      S_FINISH: cmd.load_result = !status.out_busy;
      default: cmd = '0;
    endcase
  end

endmodule

>>> hdl/gmc_dpath.sv
module gmc_dpath (
  input  logic                          clk,
  input  logic                          rst,
  input  gmc_pkg::cmd_t                 cmd,
  output gmc_pkg::status_t              status,
  input  logic [gmc_pkg::VIDX_W-1:0]    row_index,
  input  logic [gmc_pkg::ROW_W-1:0]     row_bits,
  input  logic [gmc_pkg::CFG_W-1:0]     color_limit,
  input  logic [gmc_pkg::CFG_W-1:0]     vertex_count,
  input  logic                          m_tready,
  output logic                          m_tvalid,
  output logic                          colorable
);
  import gmc_pkg::*;

  logic [ROW_W-1:0]   adjacency [MAX_VERTICES];
  logic [COLOR_W-1:0] colors    [MAX_VERTICES];
  logic [COLOR_W-1:0] top_used  [MAX_VERTICES+1];
  logic [VPTR_W-1:0]  v_ptr;
  logic [COLOR_W-1:0] trial;

  logic [VPTR_W-1:0]  n_used;
  logic [VIDX_W-1:0]  v_idx;
  logic [COLOR_W-1:0] top_cur;
  logic [COLOR_W-1:0] cap_raw;
  logic [COLOR_W-1:0] cap;
  logic [MAX_VERTICES-1:0] clash;

  assign n_used  = (vertex_count > CFG_W'(MAX_VERTICES)) ? VPTR_W'(MAX_VERTICES)
                                                         : VPTR_W'(vertex_count);
  assign v_idx   = v_ptr[VIDX_W-1:0];
  assign top_cur = top_used[v_ptr];
  assign cap_raw = top_cur + COLOR_W'(1);
  assign cap     = (cap_raw > color_limit) ? COLOR_W'(color_limit) : cap_raw;

  // A neighbour other than the vertex under test that already holds the trial colour.
  always_comb begin
    for (int j = 0; j < MAX_VERTICES; j++) begin
      clash[j] = adjacency[v_idx][j] && (VIDX_W'(j) != v_idx) && (colors[j] == trial);
    end
  end

  assign status.v_done   = v_ptr >= n_used;
  assign status.v_zero   = v_ptr == '0;
  assign status.c_over   = trial > cap;
  assign status.safe     = clash == '0;
  assign status.out_busy = m_tvalid && !m_tready;

  always_ff @(posedge clk) begin
    if (cmd.write_row) adjacency[row_index] <= row_bits;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      for (int j = 0; j < MAX_VERTICES; j++) colors[j] <= '0;
      v_ptr       <= '0;
      top_used[0] <= '0;
    end else if (cmd.place) begin
      colors[v_idx]            <= trial;
      top_used[v_ptr + VPTR_W'(1)] <= (trial > top_cur) ? trial : top_cur;
      v_ptr                    <= v_ptr + VPTR_W'(1);
    end else if (cmd.back) begin
      colors[v_idx] <= '0;
      v_ptr         <= v_ptr - VPTR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.visit) begin
      trial <= colors[v_idx] + COLOR_W'(1);
    end else if (cmd.next_c) begin
      trial <= trial + COLOR_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_result) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) colorable <= cmd.found;
  end

endmodule

>>> sim/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gmc_pkg::*;

  // Searches whose predicted effort (vertex visits plus colour trials) exceeds
  // this are left out, so that no single search dominates the run time.
  localparam int unsigned SEARCH_BUDGET  = 3000;
  // Cycles without any accepted item before the run is declared hung. This
  // covers the largest search, the long receiver hold-off and the longest gaps
  // several times over.
  localparam int unsigned WATCHDOG_LIMIT = 100000;
  // Settling wait that lets a row load land after it has been accepted.
  localparam int          LOAD_SETTLE    = 8;
  localparam int unsigned HOLD_CYCLES    = 300;
  localparam int          MAX_REPORTS    = 40;

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        s_tvalid;
  logic        s_tready;
  logic [23:0] s_tdata;   // row_index [3:0], row_bits [19:4], zero [23:20]
  logic [0:0]  s_tuser;   // operation [0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // colorable [0], zero [7:1]

  graph_m_coloring_backtrack dut (
    .clk      (clk),
    .rst      (rst),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Our own copy of the block's state: the adjacency rows as loaded and the two
  // configuration registers as written over APB.
  logic [15:0] row_model [MAX_VERTICES];
  logic [4:0]  limit_model;
  logic [4:0]  count_model;

  // One entry per accepted search, oldest first.
  bit expected_colourable [$];
  bit want_colourable;

  int error_count;
  int items_sent;
  int loads_sent;
  int solves_sent;
  int solves_skipped;
  int results_seen;
  int colourable_seen;
  int configs_used;

  // Idling controls, shared between the test tasks and the two stream sides.
  bit          sender_steady;
  bit          rx_steady;
  int unsigned hold_request;
  int unsigned stall_left;
  int unsigned quiet_cycles;

  // Depth-first colouring search over the modelled state. Vertices are taken in
  // index order and colours tried from 1 upward; a vertex never goes more than
  // one colour above the highest colour used by the vertices before it. A
  // neighbour that has no colour yet (or lies beyond the vertices in use) holds
  // colour 0 and so never blocks, and a self loop is ignored because the vertex
  // under test is left out of the neighbour check. Also returns the effort, which
  // tracks the number of cycles the block will spend.
  function automatic bit search_colouring(output int unsigned steps);
    logic [4:0] colour [MAX_VERTICES];
    logic [4:0] top_used [MAX_VERTICES + 1];
    int n, v, c, cap, j;
    bit placed, safe, done, found;
    n = (count_model > MAX_VERTICES) ? MAX_VERTICES : int'(count_model);
    for (j = 0; j < MAX_VERTICES; j++) colour[j] = '0;
    top_used[0] = '0;
    steps = 0;
    v = 0;
    done = 1'b0;
    found = 1'b0;
    while (!done) begin
      if (v >= n) begin
        found = 1'b1;
        done = 1'b1;
      end else begin
        steps++;
        cap = int'(top_used[v]) + 1;
        if (cap > int'(limit_model)) cap = int'(limit_model);
        placed = 1'b0;
        c = int'(colour[v]) + 1;
        while (!placed && c <= cap) begin
          steps++;
          safe = 1'b1;
          for (j = 0; j < MAX_VERTICES; j++)
            if (j != v && row_model[v][j] && colour[j] == 5'(c)) safe = 1'b0;
          if (safe) begin
            colour[v] = 5'(c);
            top_used[v + 1] = (5'(c) > top_used[v]) ? 5'(c) : top_used[v];
            placed = 1'b1;
          end else begin
            c++;
          end
        end
        if (placed) begin
          v++;
        end else begin
          colour[v] = '0;
          if (v == 0) done = 1'b1;
          else v--;
        end
      end
    end
    return found;
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
  endtask

  // Mostly back-to-back or short gaps, now and then a long one.
  function automatic int sender_gap();
    int r;
    if (sender_steady) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Offers one item and waits for it to be taken. The valid is left high on
  // return, so that a following item without a gap goes out back to back; the
  // caller that stops sending lowers it. On acceptance the model is updated and,
  // for a search, its answer is queued.
  task automatic send_item(op_t op, logic [3:0] row_index, logic [15:0] row_bits);
    int gap;
    int unsigned steps;
    gap = sender_gap();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {4'b0000, row_bits, row_index};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (op == OP_LOAD) begin
      row_model[row_index] = row_bits;
      loads_sent++;
    end else begin
      expected_colourable.push_back(search_colouring(steps));
      solves_sent++;
    end
  endtask

  // Issues a search unless the present graph would keep the block busy for too
  // long. The data bits of a search item carry no meaning, so they are random.
  task automatic try_solve();
    int unsigned steps;
    bit ignored;
    ignored = search_colouring(steps);
    if (steps <= SEARCH_BUDGET) send_item(OP_SOLVE, 4'($urandom), 16'($urandom));
    else solves_skipped++;
  endtask

  // Stops offering items and waits until every search answer has come back,
  // then lets any row load still in flight settle.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    while (expected_colourable.size() != 0) @(posedge clk);
    repeat (LOAD_SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t r, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {r, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (r == REG_COLOR_LIMIT) limit_model = value[4:0];
    else count_model = value[4:0];
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_register(reg_idx_t r, logic [4:0] want);
    logic [31:0] value;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {r, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    value = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    if (value !== {27'd0, want})
      report_mismatch(r == REG_COLOR_LIMIT ? "color_limit readback" : "vertex_count readback",
                      value, {27'd0, want});
  endtask

  // Registers only change once the block has gone idle.
  task automatic set_config(logic [4:0] colour_limit, logic [4:0] vertex_count);
    drain_results();
    write_reg(REG_COLOR_LIMIT, {27'd0, colour_limit});
    write_reg(REG_VERTEX_COUNT, {27'd0, vertex_count});
    check_register(REG_COLOR_LIMIT, colour_limit);
    check_register(REG_VERTEX_COUNT, vertex_count);
    configs_used++;
  endtask

  // Register values straight after reset.
  task automatic test_reset_values();
    check_register(REG_COLOR_LIMIT, 5'd3);
    check_register(REG_VERTEX_COUNT, 5'd4);
  endtask

  // Short hand-picked graphs. Every row is loaded first, so that no search ever
  // reads a row that was never written.
  task automatic test_directed_graphs();
    int i;
    // A four-vertex cycle in rows 0 to 3, empty rows above it and a last row
    // that names every vertex, itself included.
    send_item(OP_LOAD, 4'd0, 16'h000A);
    send_item(OP_LOAD, 4'd1, 16'h0005);
    send_item(OP_LOAD, 4'd2, 16'h000A);
    send_item(OP_LOAD, 4'd3, 16'h0005);
    for (i = 4; i < 15; i++) send_item(OP_LOAD, 4'(i), 16'h0000);
    send_item(OP_LOAD, 4'd15, 16'hFFFF);
    // Reset settings: three colours, four vertices; an even cycle colours.
    send_item(OP_SOLVE, 4'd0, 16'h0000);
    // No vertices in use always colours.
    set_config(5'd3, 5'd0);
    send_item(OP_SOLVE, 4'd15, 16'hFFFF);
    // No colours at all cannot colour a nonempty graph.
    set_config(5'd0, 5'd4);
    send_item(OP_SOLVE, 4'd0, 16'h0000);
    // A vertex count past the largest graph saturates to all sixteen vertices.
    // The last vertex then needs a third colour.
    set_config(5'd2, 5'd31);
    send_item(OP_SOLVE, 4'd0, 16'h0000);
    set_config(5'd31, 5'd31);
    send_item(OP_SOLVE, 4'd0, 16'h0000);
    // A complete graph on four vertices with self loops on every vertex.
    for (i = 0; i < 4; i++) send_item(OP_LOAD, 4'(i), 16'h000F);
    set_config(5'd3, 5'd4);
    send_item(OP_SOLVE, 4'd0, 16'h0000);
    set_config(5'd4, 5'd4);
    send_item(OP_SOLVE, 4'd0, 16'h0000);
    // One vertex whose row names vertices that are not in use.
    send_item(OP_LOAD, 4'd0, 16'hFFFF);
    set_config(5'd1, 5'd1);
    send_item(OP_SOLVE, 4'd0, 16'h0000);
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering
  // small graphs at full rate, so that the output register fills and the block
  // stalls its input. Afterwards the sender waits for every answer.
  task automatic test_output_backpressure();
    int i;
    set_config(5'd3, 5'd3);
    hold_request = HOLD_CYCLES;
    sender_steady = 1'b1;
    repeat (4) begin
      for (i = 0; i < 3; i++) send_item(OP_LOAD, 4'(i), 16'($urandom) & 16'h0007);
      send_item(OP_SOLVE, 4'($urandom), 16'($urandom));
    end
    sender_steady = 1'b0;
    drain_results();
  endtask

  // A random graph over the vertices in use: symmetric edges at a random
  // density, now and then a self loop or stray bits naming unused vertices,
  // loaded in ascending or descending order and followed by a search within budget.
  task automatic send_graph();
    logic [15:0] rows [MAX_VERTICES];
    logic [15:0] in_use;
    int n, density, i, j;
    n = (count_model > MAX_VERTICES) ? MAX_VERTICES : int'(count_model);
    in_use = (n >= MAX_VERTICES) ? 16'hFFFF : 16'((1 << n) - 1);
    density = $urandom_range(10, 90);
    for (i = 0; i < MAX_VERTICES; i++) rows[i] = '0;
    for (i = 0; i < n; i++)
      for (j = i + 1; j < n; j++)
        if ($urandom_range(0, 99) < density) begin
          rows[i][j] = 1'b1;
          rows[j][i] = 1'b1;
        end
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) == 0) rows[i][i] = 1'b1;
      if ($urandom_range(0, 3) == 0) rows[i] = rows[i] | (16'($urandom) & ~in_use);
    end
    if ($urandom_range(0, 1) == 1) begin
      for (i = 0; i < n; i++) send_item(OP_LOAD, 4'(i), rows[i]);
    end else begin
      for (i = n - 1; i >= 0; i--) send_item(OP_LOAD, 4'(i), rows[i]);
    end
    if (n < MAX_VERTICES && $urandom_range(0, 3) == 0)
      send_item(OP_LOAD, 4'($urandom_range(n, MAX_VERTICES - 1)), 16'($urandom));
    try_solve();
    if ($urandom_range(0, 7) == 0) try_solve();
  endtask

  // Phases of random graphs, each under its own register setting. Most use
  // small graphs; a few run the full sixteen vertices. About one pick in five
  // is noise: lone row loads with arbitrary bits or repeated searches.
  task automatic test_random_graphs();
    int unsigned phase_count [10];
    int unsigned phase_limit [10];
    int p, first_item;
    phase_count = '{5, 8, 16, 6, 31, 0, 12, 7, 4, 9};
    phase_limit = '{3, 3, 4, 2, 5, 1, 16, 31, 2, 4};
    for (p = 0; p < 10; p++) begin
      set_config(5'(phase_limit[p]), 5'(phase_count[p]));
      sender_steady = (p % 3 == 2);
      rx_steady = (p % 4 == 3);
      first_item = items_sent;
      while (items_sent - first_item < 120) begin
        if ($urandom_range(0, 99) < 80) begin
          send_graph();
        end else if ($urandom_range(0, 2) == 0) begin
          try_solve();
        end else begin
          send_item(OP_LOAD, 4'($urandom), 16'($urandom));
        end
      end
    end
    sender_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  // Receiver: every cycle either ready or in a stall of random length, unless a
  // test has asked for a long hold-off or a stretch without stalls.
  initial begin
    m_tready <= 1'b0;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else if (!rx_steady && $urandom_range(0, 99) < 25) begin
        m_tready <= 1'b0;
        case ($urandom_range(0, 99)) inside
          [0:79]:  stall_left = $urandom_range(0, 2);
          [80:96]: stall_left = $urandom_range(3, 11);
          default: stall_left = $urandom_range(30, 120);
        endcase
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // Each answer taken from the output stream is compared with the oldest
  // expectation.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (expected_colourable.size() == 0) begin
        report_mismatch("result with no search pending", {24'd0, m_tdata}, 32'd0);
      end else begin
        want_colourable = expected_colourable.pop_front();
        results_seen++;
        if (want_colourable) colourable_seen++;
        if (m_tdata[0] !== want_colourable)
          report_mismatch("colorable", {31'd0, m_tdata[0]}, {31'd0, want_colourable});
        if (m_tdata[7:1] !== 7'd0)
          report_mismatch("m_tdata padding", {25'd0, m_tdata[7:1]}, 32'd0);
      end
    end
  end

  // Hang detection: counts cycles in which nothing moves on any port.
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("Timeout: nothing accepted for %0d cycles", WATCHDOG_LIMIT);
    $display("FAILURE");
    $finish;
  end

  initial begin
    rst      <= 1'b1;
    psel     <= 1'b0;
    penable  <= 1'b0;
    pwrite   <= 1'b0;
    paddr    <= '0;
    pwdata   <= '0;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;
    s_tuser  <= OP_LOAD;
    limit_model = 5'd3;
    count_model = 5'd4;
    for (int i = 0; i < MAX_VERTICES; i++) row_model[i] = '0;
    sender_steady = 1'b0;
    rx_steady = 1'b0;
    hold_request = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_values();
    test_directed_graphs();
    test_output_backpressure();
    test_random_graphs();

    // Let every answer come home, then a short tail for anything stray.
    drain_results();
    repeat (20) @(posedge clk);

    $display("Run covered %0d row loads and %0d searches over %0d register settings.",
             loads_sent, solves_sent, configs_used);
    $display("%0d answers checked (%0d colourable, %0d not); %0d oversized searches left out.",
             results_seen, colourable_seen, results_seen - colourable_seen, solves_skipped);
    if (error_count == 0 && expected_colourable.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
